// ===== hdl/base64_stream_encoder_assert.svh =====
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication, checked on clk and quiet in reset
`define B64E_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// next-cycle implication, checked on clk and quiet in reset
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

// ===== hdl/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream encoder
`default_nettype none

package b64e_pkg;

  localparam int unsigned B64E_QUEUE_DEPTH = 2;

  localparam logic [6:0]  PAD_CHAR    = 7'h3D;
  localparam logic [15:0] CAP_RESET   = 16'hFFFF;
  localparam logic [16:0] GROUP_CHARS = 17'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       final_char;
    logic       overflow;
  } out_item_t;

  // one classified group handed from front to back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       fin;
    logic       ovf;
  } group_t;

  function automatic logic [6:0] sym(input logic [5:0] six);
    logic [6:0] s;
    logic [6:0] r;
    s = {1'b0, six};
    case (six) inside
      [6'd0:6'd25]:  r = s + 7'h41;
      [6'd26:6'd51]: r = s + 7'h47;
      [6'd52:6'd61]: r = s - 7'd4;
      6'd62:         r = 7'h2B;
      default:       r = 7'h2F;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b64e_fifo.sv =====
// small group queue between the front and back halves
`default_nettype none

module b64e_fifo #(
  parameter int unsigned DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  b64e_pkg::group_t     wdata,
  output logic                 full,
  input  wire logic            pop,
  output b64e_pkg::group_t     rdata,
  output logic                 empty
);
  import b64e_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  group_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64e_front.sv =====
// front half: collects bytes into groups, tracks the count and decides overflow
`default_nettype none

module b64e_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  b64e_pkg::in_item_t    in_item,
  input  wire logic [15:0]      cap,
  output logic                  q_push,
  input  wire logic             q_full,
  output b64e_pkg::group_t      q_data
);
  import b64e_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] held_r, held_nxt;
  logic [15:0] count_r, count_nxt;
  logic        drop_r, drop_nxt;

  logic        accept;
  logic        eom;
  logic [7:0]  b;
  logic [1:0]  nbytes;
  logic        complete;
  logic [16:0] count_sum;
  logic        ovf;

  assign in_full   = q_full;
  assign accept    = in_push & ~q_full;
  assign eom       = in_item.end_of_message;
  assign b         = in_item.in_byte;
  assign nbytes    = phase_r + 2'd1;
  assign complete  = ~drop_r & ((nbytes == 2'd3) | eom);
  assign count_sum = {1'b0, count_r} + GROUP_CHARS;
  assign ovf       = count_sum > {1'b0, cap};
  assign q_push    = accept & complete;

  always_comb begin
    q_data.b0     = (nbytes == 2'd1) ? b : held_r[15:8];
    q_data.b1     = (nbytes == 2'd1) ? 8'd0 : ((nbytes == 2'd2) ? b : held_r[7:0]);
    q_data.b2     = (nbytes == 2'd3) ? b : 8'd0;
    q_data.nbytes = nbytes;
    q_data.fin    = eom;
    q_data.ovf    = ovf;
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (accept) begin
      if (drop_r) begin
        if (eom) begin
          phase_nxt = '0;
          held_nxt  = '0;
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end else if (!complete) begin
        if (nbytes == 2'd1) begin
          held_nxt = {b, 8'd0};
        end else begin
          held_nxt = {held_r[15:8], b};
        end
        phase_nxt = nbytes;
      end else begin
        phase_nxt = '0;
        held_nxt  = '0;
        if (eom) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end else if (ovf) begin
          // rest of the message is thrown away up to its final byte
          drop_nxt = 1'b1;
        end else begin
          count_nxt = count_sum[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      held_r  <= '0;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64e_back.sv =====
// back half: turns queued groups into characters, one per cycle into the output register while it is free
`default_nettype none

module b64e_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  b64e_pkg::group_t      q_data,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output b64e_pkg::out_item_t   out_item
);
  import b64e_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  out_item_t   out_r, out_nxt;

  logic        load;
  logic        last;
  out_item_t   ch;

  // output slot frees when empty or when its request is taken
  assign load      = ~vld_r | out_pop;
  assign last      = q_data.ovf | (idx_r == 2'd3);
  assign q_pop     = load & ~q_empty & last;
  assign out_empty = ~vld_r;
  assign out_item  = out_r;

  always_comb begin
    ch.final_char = 1'b0;
    ch.overflow   = 1'b0;
    case (idx_r)
      2'd0: ch.out_char = sym(q_data.b0[7:2]);
      2'd1: ch.out_char = sym({q_data.b0[1:0], q_data.b1[7:4]});
      2'd2: ch.out_char = (q_data.nbytes != 2'd1) ?
                          sym({q_data.b1[3:0], q_data.b2[7:6]}) : PAD_CHAR;
      default: begin
        ch.out_char   = (q_data.nbytes == 2'd3) ? sym(q_data.b2[5:0]) : PAD_CHAR;
        ch.final_char = q_data.fin;
      end
    endcase
    if (q_data.ovf) begin
      ch.out_char   = 7'd0;
      ch.final_char = 1'b1;
      ch.overflow   = 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    out_nxt = out_r;
    if (load) begin
      if (!q_empty) begin
        out_nxt = ch;
        vld_nxt = 1'b1;
        idx_nxt = last ? 2'd0 : idx_r + 2'd1;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/base64_stream_encoder.sv =====
// top level of the base64 stream encoder: capacity register, front, group queue, back
//
//   channel   direction  handshake           payload
//   in_       input      in_push / in_full   in_item   (in_byte, end_of_message)
//   out_      output     out_empty / out_pop out_item  (out_char, final_char, overflow)
//   cfg_      input      cfg_we              cfg_wdata (out_capacity)
//
// a byte is taken every cycle while the group queue has room; the front classifies it
// in the same cycle. the back emits one character per cycle from the queue head while
// the output request is taken, four per group and one for an overflow group, so the
// sustained rate is set by the one-character output register. reset clears all message
// state, empties the queue and sets the capacity to 65535. a stalled out_pop holds the
// output request; the queue then fills and in_full rises.
`default_nettype none
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  b64e_pkg::in_item_t    in_item,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output b64e_pkg::out_item_t   out_item,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata
);
  import b64e_pkg::*;

  logic [15:0] cap_r, cap_nxt;
  logic        q_push, q_full, q_pop, q_empty;
  group_t      q_wdata, q_rdata;

  assign cap_nxt = cfg_we ? cfg_wdata : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .cap     (cap_r),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // an overflow request closes the message and carries no character
  `B64E_ASSERT_IMPLY(a_ovf_is_last, !out_empty && out_item.overflow,
                     out_item.final_char && out_item.out_char == 7'd0)

  // a pushed group is waiting in the queue on the next cycle
  `B64E_ASSERT_NEXT(a_push_lands, q_push, !q_empty)

  // with nothing queued, taking the output request leaves the output empty
  `B64E_ASSERT_NEXT(a_drain_empty, out_pop && !out_empty && q_empty, out_empty)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the base64 stream encoder
`timescale 1ns / 1ps

module tb;
  import b64e_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_TIME  = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 48;

  typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_BURSTY} pop_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_item_t    in_item = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  base64_stream_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // encoder state mirrored in the testbench
  string       b64_letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [15:0] cap_setting = 16'hFFFF;
  logic [1:0]  enc_phase = '0;
  logic [15:0] enc_held = '0;
  logic [15:0] enc_count = '0;
  logic        enc_dropping = 1'b0;
  out_item_t   expected_chars[$];

  int errors = 0;
  int idle_cycles = 0;

  // sender pacing
  bit pacing_on = 1'b1;
  int burst_left = 0;

  // receiver stall pattern
  int        hold_request = 0;
  int        hold_left = 0;
  int        pattern_left = 0;
  int        pattern_tick = 0;
  pop_mode_t pop_mode = POP_ALWAYS;

  function automatic logic [6:0] letter(input logic [5:0] six);
    byte c;
    c = b64_letters[six];
    return c[6:0];
  endfunction

  task automatic clear_message_state;
    enc_phase = '0;
    enc_held = '0;
    enc_count = '0;
    enc_dropping = 1'b0;
  endtask

  task automatic push_char(input logic [6:0] ch, input logic fin);
    expected_chars.push_back('{out_char: ch, final_char: fin, overflow: 1'b0});
  endtask

  task automatic predict_byte(input in_item_t item);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    int unsigned n;
    if (enc_dropping) begin
      if (item.end_of_message) clear_message_state();
      return;
    end
    n = (enc_phase == 2'd2) ? 3 : enc_phase + 1;
    if (n < 3 && !item.end_of_message) begin
      if (n == 1) enc_held = {item.in_byte, 8'h00};
      else enc_held[7:0] = item.in_byte;
      enc_phase = n[1:0];
      return;
    end
    b0 = (n == 1) ? item.in_byte : enc_held[15:8];
    b1 = (n == 1) ? 8'h00 : ((n == 2) ? item.in_byte : enc_held[7:0]);
    b2 = (n == 3) ? item.in_byte : 8'h00;
    if ({1'b0, enc_count} + 17'd4 > {1'b0, cap_setting}) begin
      expected_chars.push_back('{out_char: 7'd0, final_char: 1'b1, overflow: 1'b1});
      if (item.end_of_message) begin
        clear_message_state();
      end else begin
        enc_dropping = 1'b1;
        enc_phase = '0;
        enc_held = '0;
      end
      return;
    end
    push_char(letter(b0[7:2]), 1'b0);
    push_char(letter({b0[1:0], b1[7:4]}), 1'b0);
    push_char((n > 1) ? letter({b1[3:0], b2[7:6]}) : PAD_CHAR, 1'b0);
    push_char((n > 2) ? letter(b2[5:0]) : PAD_CHAR, item.end_of_message);
    enc_count = enc_count + 16'd4;
    enc_phase = '0;
    enc_held = '0;
    if (item.end_of_message) clear_message_state();
  endtask

  task automatic compare_field(input string name, input logic [6:0] exp_v,
                               input logic [6:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_chars.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual char %0h final %0b overflow %0b",
               $time, got.out_char, got.final_char, got.overflow);
      return;
    end
    want = expected_chars.pop_front();
    compare_field("out_char", want.out_char, got.out_char);
    compare_field("final_char", {6'd0, want.final_char}, {6'd0, got.final_char});
    compare_field("overflow", {6'd0, want.overflow}, {6'd0, got.overflow});
  endtask

  // predict on every accepted request, then check every accepted result
  always @(posedge clk) begin
    logic took;
    took = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_byte(in_item);
        took = 1'b1;
      end
      if (out_pop && !out_empty) begin
        check_result(out_item);
        took = 1'b1;
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 expected_chars.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pop_mode = pop_mode_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(10, 60);
      end
      pattern_left--;
      pattern_tick++;
      case (pop_mode)
        POP_ALWAYS: out_pop <= 1'b1;
        POP_HALF:   out_pop <= ($urandom_range(0, 1) == 1);
        POP_SPARSE: out_pop <= ($urandom_range(0, 3) == 0);
        default:    out_pop <= ((pattern_tick % 7) < 3);
      endcase
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] data, input logic eom);
    int gap;
    if (pacing_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left--;
    end
    in_item <= '{in_byte: data, end_of_message: eom};
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_item(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // stop sending and wait until every expected result is in, then let the block settle
  task automatic wait_for_results;
    in_push <= 1'b0;
    @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_TIME) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_setting = value;
  endtask

  task automatic test_encoding;
    logic [7:0] msg[$];
    msg = {8'h4D, 8'h61, 8'h6E};
    send_message(msg);
    msg = {8'h00};
    send_message(msg);
    msg = {8'hFF, 8'hFF};
    send_message(msg);
    msg = {8'hFF, 8'hAA, 8'h55, 8'h00};
    send_message(msg);
    wait_for_results();
  endtask

  task automatic test_capacity_limit;
    logic [7:0] msg[$];
    // overflow on the final byte
    write_capacity(16'd0);
    msg = {8'h41};
    send_message(msg);
    wait_for_results();
    // one group fits, the second overflows and the tail is dropped
    write_capacity(16'd4);
    msg = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07};
    send_message(msg);
    wait_for_results();
    // capacity lowered between groups of one message
    write_capacity(16'hFFFF);
    send_item(8'h10, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h30, 1'b0);
    wait_for_results();
    write_capacity(16'd4);
    send_item(8'h40, 1'b0);
    send_item(8'h50, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_messages;
    logic [15:0] cap;
    int          sent;
    int          len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       cap = 16'hFFFF;
        1:       cap = 16'd0;
        2:       cap = 16'($urandom_range(4, 40));
        3:       cap = 16'($urandom_range(0, 65535));
        4:       cap = 16'($urandom_range(1, 3));
        default: cap = 16'($urandom_range(8, 80));
      endcase
      write_capacity(cap);
      pacing_on = (phase != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        send_random_message(len);
        sent += len;
      end
      wait_for_results();
    end
    pacing_on = 1'b1;
  endtask

  task automatic test_backpressure;
    pacing_on = 1'b0;
    hold_request = HOLD_CYCLES;
    send_random_message(36);
    wait_for_results();
    pacing_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_encoding();
    test_capacity_limit();
    test_random_messages();
    write_capacity(16'hFFFF);
    test_backpressure();
    wait_for_results();
    if (expected_chars.size() != 0) errors++;
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/b64e_pkg.sv
hdl/b64e_fifo.sv
hdl/b64e_front.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
tb/tb.sv
